[rtl/core/thread_stack_bounds_table_defines.svh]
// assertion macros shared by the rtl
`ifndef THREAD_STACK_BOUNDS_TABLE_DEFINES_SVH
`define THREAD_STACK_BOUNDS_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSBT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsbt same-cycle check failed");

// next-cycle implication, checked out of reset
`define TSBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsbt next-cycle check failed");

`endif

[rtl/core/tsbt_pkg.sv]
`default_nettype none

package tsbt_pkg;

  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 32;
  // stored address width: input fields carry 32 bits at most
  localparam int AW        = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_CHECK_PTR  = 2'd2,
    OP_CHECK_BASE = 2'd3
  } opcode_t;

  // per-slot compare results against the current query
  typedef struct packed {
    logic valid;
    logic hit;
    logic below;
    logic above;
    logic at_end;
  } slot_status_t;

endpackage

`default_nettype wire

[rtl/core/tsbt_slot.sv]
`default_nettype none

module tsbt_slot (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic                     clr_en,
  input  wire logic [31:0]              wr_tid,
  input  wire logic [tsbt_pkg::AW-1:0]  wr_start,
  input  wire logic [tsbt_pkg::AW-1:0]  wr_len,
  input  wire logic [31:0]              q_tid,
  input  wire logic [tsbt_pkg::AW-1:0]  q_addr,
  output tsbt_pkg::slot_status_t        status
);
  import tsbt_pkg::*;

  logic          valid_r;
  logic [31:0]   tid_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] len_r;
  logic [AW:0]   end_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end else if (clr_en) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tid_r   <= wr_tid;
      start_r <= wr_start;
      len_r   <= wr_len;
    end
  end

  // region end one bit wider, never wraps
  assign end_w = {1'b0, start_r} + {1'b0, len_r};

  assign status.valid  = valid_r;
  assign status.hit    = valid_r && (tid_r == q_tid);
  assign status.below  = q_addr < start_r;
  assign status.above  = {1'b0, q_addr} > end_w;
  assign status.at_end = {1'b0, q_addr} == end_w;

endmodule

`default_nettype wire

[rtl/core/thread_stack_bounds_table.sv]
// channel | ports                                                   | direction
// --------+---------------------------------------------------------+----------
// input   | in_valid/in_ready, in_opcode, in_thread_id,             | in
//         | in_address, in_region_size                              |
// result  | out_valid/out_ready, out_verdict, out_entry_found,      | out
//         | out_table_full                                          |
//
// one transfer in, one transfer out per operation, through the input register stage and
// the result register; one operation per cycle sustained while out_ready stays high
// the cycle is set by the parallel tag compare and region-end add in every slot;
// table updates land at the edge the result is registered, so the next operation sees them
// synchronous active-low reset empties every slot; stored fields need no reset
// a stalled result holds both registers; in_ready drops only while both are occupied
`default_nettype none
`include "thread_stack_bounds_table_defines.svh"

module thread_stack_bounds_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_thread_id,
  input  wire logic [31:0] in_address,
  input  wire logic [31:0] in_region_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_verdict,
  output logic             out_entry_found,
  output logic             out_table_full
);
  import tsbt_pkg::*;

  // input register stage
  logic          s1_valid_r;
  opcode_t       s1_op_r;
  logic [31:0]   s1_tid_r;
  logic [AW-1:0] s1_addr_r;
  logic [AW-1:0] s1_size_r;

  // result register
  logic out_valid_r;
  logic verdict_r;
  logic found_r;
  logic full_r;

  logic verdict_nxt;
  logic full_nxt;

  logic advance;

  slot_status_t       slot_st [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] below_vec;
  logic [ENTRIES-1:0] above_vec;
  logic [ENTRIES-1:0] end_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] hit_first;
  logic [ENTRIES-1:0] free_first;
  logic [ENTRIES-1:0] wr_vec;
  logic [ENTRIES-1:0] clr_vec;

  logic found;
  logic any_free;
  logic ops_ok;
  logic sel_below;
  logic sel_above;
  logic sel_end;

  // the stage moves on whenever the result register is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= opcode_t'(in_opcode);
      s1_tid_r  <= in_thread_id;
      s1_addr_r <= in_address[AW-1:0];
      s1_size_r <= in_region_size[AW-1:0];
    end
  end

  // slot array: every slot compares against the query in parallel
  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    tsbt_slot u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_vec[g]),
      .clr_en   (clr_vec[g]),
      .wr_tid   (s1_tid_r),
      .wr_start (s1_addr_r),
      .wr_len   (s1_size_r),
      .q_tid    (s1_tid_r),
      .q_addr   (s1_addr_r),
      .status   (slot_st[g])
    );
    assign valid_vec[g] = slot_st[g].valid;
    assign hit_vec[g]   = slot_st[g].hit;
    assign below_vec[g] = slot_st[g].below;
    assign above_vec[g] = slot_st[g].above;
    assign end_vec[g]   = slot_st[g].at_end;
  end

  assign free_vec = ~valid_vec;

  // lowest set bit wins, for both the match and the free slot
  assign hit_first  = hit_vec & (~hit_vec + ENTRIES'(1));
  assign free_first = free_vec & (~free_vec + ENTRIES'(1));

  assign found     = |hit_vec;
  assign any_free  = |free_vec;
  assign ops_ok    = (s1_addr_r != '0) && (s1_size_r != '0);
  assign sel_below = |(hit_first & below_vec);
  assign sel_above = |(hit_first & above_vec);
  assign sel_end   = |(hit_first & end_vec);

  // table writes: overwrite a matching slot, else fill the lowest free one; unregister clears the match
  always_comb begin
    wr_vec  = '0;
    clr_vec = '0;
    if (advance) begin
      if (s1_op_r == OP_REGISTER && ops_ok) begin
        wr_vec = found ? hit_first : free_first;
      end
      if (s1_op_r == OP_UNREGISTER) begin
        clr_vec = hit_first;
      end
    end
  end

  always_comb begin
    verdict_nxt = 1'b0;
    full_nxt    = 1'b0;
    unique case (s1_op_r)
      OP_REGISTER: begin
        if (ops_ok) begin
          verdict_nxt = found || any_free;
          full_nxt    = !(found || any_free);
        end
      end
      OP_UNREGISTER: begin
        verdict_nxt = found;
      end
      OP_CHECK_PTR: begin
        // unknown thread reads as valid; bounds inclusive at both ends
        verdict_nxt = !(found && (sel_below || sel_above));
      end
      OP_CHECK_BASE: begin
        verdict_nxt = found && sel_end;
      end
      default: begin
        verdict_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_r <= verdict_nxt;
      found_r   <= found;
      full_r    <= full_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_entry_found = found_r;
  assign out_table_full  = full_r;

  // a thread id never sits in two valid slots
  `TSBT_ASSERT_IMPL(a_single_hit, s1_valid_r, $onehot0(hit_vec))
  // full is only reported when no slot is free
  `TSBT_ASSERT_IMPL(a_full_no_free, advance && full_nxt, &valid_vec)
  // a full report never carries an accepted verdict
  `TSBT_ASSERT_NEXT(a_full_rejects, advance && full_nxt, out_table_full && !out_verdict)
  // a register or unregister touches at most one slot
  `TSBT_ASSERT_IMPL(a_one_slot_write, advance, $onehot0(wr_vec | clr_vec))

endmodule

`default_nettype wire
